[src/spcr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package spcr_pkg;

	localparam int COMPONENT_WIDTH = 16;
	localparam int SCALAR_W        = 16;
	localparam int DAMP_W          = 16;
	localparam int QUEUE_DEPTH     = 4;
	localparam int FRAC_BITS       = 16;
	localparam int USER_W          = 2;
	localparam int USER_CONTACT    = 0;
	localparam int USER_SAT        = 1;

	// front-to-back item: va, vb, r (3 x cw+1), t, n2, ma, mb, contact, exch
	function automatic int item_width(input int cw);
		return 13 * cw + 41;
	endfunction

	function automatic int in_width(input int cw);
		return 12 * cw + 4 * SCALAR_W;
	endfunction

	function automatic int byte_pad(input int w);
		return ((w + 7) / 8) * 8;
	endfunction

endpackage
`default_nettype wire

[src/spcr_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module spcr_front #(
	parameter int COMPONENT_WIDTH = spcr_pkg::COMPONENT_WIDTH
) (
	input  wire logic                                             clk,
	input  wire logic                                             arst_n,
	input  wire logic                                             in_valid,
	output logic                                                  in_ready,
	input  wire logic [spcr_pkg::in_width(COMPONENT_WIDTH)-1:0]   in_data,
	input  wire logic                                             q_full,
	output logic                                                  push,
	output logic [spcr_pkg::item_width(COMPONENT_WIDTH)-1:0]      item
);
	localparam int W   = COMPONENT_WIDTH;
	localparam int SW  = spcr_pkg::SCALAR_W;
	localparam int PW  = 2 * W + 2;
	localparam int RQW = 2 * (SW + 1);
	localparam int LW  = (PW > RQW) ? PW : RQW;
	localparam int IW  = spcr_pkg::item_width(W);

	logic en;

	logic                    valid_s1, valid_s2, valid_s3;
	logic signed [W:0]       r_s1 [3];
	logic signed [W:0]       v_s1 [3];
	logic [3*W-1:0]          va_s1, vb_s1;
	logic [SW-1:0]           rad_a_s1, rad_b_s1, ma_s1, mb_s1;

	logic signed [PW-1:0]    rr_s2 [3];
	logic signed [PW-1:0]    rv_s2 [3];
	logic [RQW-1:0]          rsq_s2;
	logic [3*W-1:0]          va_s2, vb_s2;
	logic [3*(W+1)-1:0]      r_s2;
	logic [SW-1:0]           ma_s2, mb_s2;

	logic [IW-1:0]           item_s3;

	logic [PW-1:0]           n2_c;
	logic signed [PW+1:0]    dot_c;
	logic [PW-1:0]           t_c;
	logic                    contact_c, exch_c;
	logic [SW:0]             rsum_c;

	assign en       = !(valid_s3 && q_full);
	assign in_ready = en;
	assign push     = valid_s3 && !q_full;
	assign item     = item_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1: relative offset and velocity
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				r_s1[i] <= (W+1)'(signed'(in_data[i*W +: W]))
					- (W+1)'(signed'(in_data[6*W + i*W +: W]));
				v_s1[i] <= (W+1)'(signed'(in_data[3*W + i*W +: W]))
					- (W+1)'(signed'(in_data[9*W + i*W +: W]));
			end
			va_s1    <= in_data[3*W +: 3*W];
			vb_s1    <= in_data[9*W +: 3*W];
			rad_a_s1 <= in_data[12*W +: SW];
			rad_b_s1 <= in_data[12*W + SW +: SW];
			ma_s1    <= in_data[12*W + 2*SW +: SW];
			mb_s1    <= in_data[12*W + 3*SW +: SW];
		end
	end

	assign rsum_c = (SW+1)'(rad_a_s1) + (SW+1)'(rad_b_s1);

	// stage 2: squares and dot terms
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				rr_s2[i] <= PW'(r_s1[i]) * PW'(r_s1[i]);
				rv_s2[i] <= PW'(r_s1[i]) * PW'(v_s1[i]);
				r_s2[i*(W+1) +: W+1] <= r_s1[i];
			end
			rsq_s2 <= RQW'(rsum_c) * RQW'(rsum_c);
			va_s2  <= va_s1;
			vb_s2  <= vb_s1;
			ma_s2  <= ma_s1;
			mb_s2  <= mb_s1;
		end
	end

	// stage 3: classify
	always_comb begin
		n2_c  = PW'(rr_s2[0][PW-2:0]) + PW'(rr_s2[1][PW-2:0]) + PW'(rr_s2[2][PW-2:0]);
		dot_c = (PW+2)'(rv_s2[0]) + (PW+2)'(rv_s2[1]) + (PW+2)'(rv_s2[2]);
		contact_c = (dot_c <= 0) && (LW'(n2_c) < LW'(rsq_s2));
		t_c = contact_c ? PW'(-dot_c) : '0;
		exch_c = contact_c && (n2_c != '0) && ((ma_s2 | mb_s2) != '0);
	end

	always_ff @(posedge clk) begin
		if (en)
			item_s3 <= {exch_c, contact_c, mb_s2, ma_s2, n2_c, t_c, r_s2, vb_s2, va_s2};
	end

endmodule
`default_nettype wire

[src/spcr_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module spcr_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = spcr_pkg::QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic              pop,
	output logic [DATA_W-1:0]      rd_data,
	output logic                   full,
	output logic                   empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

[src/spcr_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module spcr_div #(
	parameter int NUM_W = 68,
	parameter int DEN_W = 51,
	parameter int QUO_W = 19
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0]      quo
);
	localparam int RW = ((DEN_W + QUO_W) > NUM_W) ? (DEN_W + QUO_W) : NUM_W;

	logic [RW-1:0]    rem_q [QUO_W];
	logic [DEN_W-1:0] den_q [QUO_W];
	logic [QUO_W-1:0] quo_q [QUO_W];

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		localparam int J = QUO_W - 1 - k;
		logic [RW-1:0]    rem_in, trial;
		logic [DEN_W-1:0] den_in;
		logic [QUO_W-1:0] quo_in;

		if (k == 0) begin : g_first
			assign rem_in = RW'(num);
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign den_in = den_q[k-1];
			assign quo_in = quo_q[k-1];
		end

		assign trial = RW'(den_in) << J;

		always_ff @(posedge clk) begin
			if (en) begin
				den_q[k] <= den_in;
				if (rem_in >= trial) begin
					rem_q[k] <= rem_in - trial;
					quo_q[k] <= quo_in | (QUO_W'(1) << J);
				end else begin
					rem_q[k] <= rem_in;
					quo_q[k] <= quo_in;
				end
			end
		end
	end

	assign quo = quo_q[QUO_W-1];

endmodule
`default_nettype wire

[src/spcr_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module spcr_back #(
	parameter int COMPONENT_WIDTH = spcr_pkg::COMPONENT_WIDTH
) (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	input  wire logic [spcr_pkg::DAMP_W-1:0]                  damping,
	input  wire logic [spcr_pkg::item_width(COMPONENT_WIDTH)-1:0] item,
	input  wire logic                                         q_empty,
	output logic                                              pop,
	output logic                                              out_valid,
	input  wire logic                                         out_ready,
	output logic [3*COMPONENT_WIDTH-1:0]                      new_vel_a,
	output logic [3*COMPONENT_WIDTH-1:0]                      new_vel_b,
	output logic                                              contact,
	output logic                                              saturated
);
	localparam int W   = COMPONENT_WIDTH;
	localparam int SW  = spcr_pkg::SCALAR_W;
	localparam int PW  = 2 * W + 2;
	localparam int MW  = W + SW + 2;
	localparam int DW  = PW + SW + 1;
	localparam int NW  = MW + PW;
	localparam int QW  = W + 3;
	localparam int AW  = W + 5;
	localparam int KW  = spcr_pkg::DAMP_W + 2;
	localparam int XW  = AW + KW;
	localparam int YW  = XW - spcr_pkg::FRAC_BITS;
	localparam int FB  = spcr_pkg::FRAC_BITS;
	localparam logic signed [YW-1:0] SMAX = YW'((1 << (W - 1)) - 1);
	localparam logic signed [YW-1:0] SMIN = -SMAX - YW'(1);

	typedef struct packed {
		logic [3*W-1:0] va;
		logic [3*W-1:0] vb;
		logic [2:0]     neg;
		logic           contact;
		logic           exch;
	} pass_t;

	logic en;

	// unpacked queue item
	logic [3*W-1:0]       it_va, it_vb;
	logic [3*(W+1)-1:0]   it_r;
	logic [PW-1:0]        it_t, it_n2;
	logic [SW-1:0]        it_ma, it_mb;
	logic                 it_contact, it_exch;
	logic [W:0]           mag_c [3];
	logic [2:0]           neg_c;

	logic                 valid_s1, valid_s2, valid_s3, valid_s4;
	logic [MW-1:0]        pa_s1 [3];
	logic [MW-1:0]        pb_s1 [3];
	logic [DW-1:0]        den_s1;
	logic [PW-1:0]        t_s1;
	pass_t                pass_s1, pass_s2;

	logic [NW-1:0]        na_s2 [3];
	logic [NW-1:0]        nb_s2 [3];
	logic [DW-1:0]        den_s2;

	logic [QW-1:0]        qa_c [3];
	logic [QW-1:0]        qb_c [3];
	pass_t                pass_d_q [QW];
	logic [QW-1:0]        valid_d_q;

	logic signed [AW-1:0] xa_s3 [3];
	logic signed [AW-1:0] xb_s3 [3];
	logic                 contact_s3;

	logic signed [XW-1:0] wa_s4 [3];
	logic signed [XW-1:0] wb_s4 [3];
	logic                 contact_s4;

	logic [KW-2:0]        keep_c;
	logic signed [YW-1:0] ya_c [3];
	logic signed [YW-1:0] yb_c [3];
	logic [3*W-1:0]       oa_c, ob_c;
	logic                 sat_c;

	assign en  = !out_valid || out_ready;
	assign pop = en && !q_empty;

	assign {it_exch, it_contact, it_mb, it_ma, it_n2, it_t, it_r, it_vb, it_va} = item;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			neg_c[i] = it_r[i*(W+1) + W];
			mag_c[i] = neg_c[i] ? (W+1)'(-it_r[i*(W+1) +: W+1]) : it_r[i*(W+1) +: W+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_d_q <= '0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
		end else if (en) begin
			valid_s1  <= !q_empty;
			valid_s2  <= valid_s1;
			valid_d_q <= {valid_d_q[QW-2:0], valid_s2};
			valid_s3  <= valid_d_q[QW-1];
			valid_s4  <= valid_s3;
		end
	end

	// stage 1: mass-weighted offsets and denominator
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pa_s1[i] <= MW'({it_mb, 1'b0}) * MW'(mag_c[i]);
				pb_s1[i] <= MW'({it_ma, 1'b0}) * MW'(mag_c[i]);
			end
			den_s1          <= DW'(DW'(it_ma) + DW'(it_mb)) * DW'(it_n2);
			t_s1            <= it_t;
			pass_s1.va      <= it_va;
			pass_s1.vb      <= it_vb;
			pass_s1.neg     <= neg_c;
			pass_s1.contact <= it_contact;
			pass_s1.exch    <= it_exch;
		end
	end

	// stage 2: numerators with half the divisor for rounding
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				na_s2[i] <= NW'(pa_s1[i]) * NW'(t_s1) + NW'(den_s1 >> 1);
				nb_s2[i] <= NW'(pb_s1[i]) * NW'(t_s1) + NW'(den_s1 >> 1);
			end
			den_s2  <= den_s1;
			pass_s2 <= pass_s1;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		spcr_div #(.NUM_W(NW), .DEN_W(DW), .QUO_W(QW)) u_div_a (
			.clk (clk), .en (en), .num (na_s2[i]), .den (den_s2), .quo (qa_c[i])
		);
		spcr_div #(.NUM_W(NW), .DEN_W(DW), .QUO_W(QW)) u_div_b (
			.clk (clk), .en (en), .num (nb_s2[i]), .den (den_s2), .quo (qb_c[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pass_d_q[0] <= pass_s2;
			for (int k = 1; k < QW; k++)
				pass_d_q[k] <= pass_d_q[k-1];
		end
	end

	// stage 3: apply the exchange
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				logic signed [AW-1:0] a0, b0, qa, qb;
				a0 = AW'(signed'(pass_d_q[QW-1].va[i*W +: W]));
				b0 = AW'(signed'(pass_d_q[QW-1].vb[i*W +: W]));
				qa = pass_d_q[QW-1].exch ? AW'(qa_c[i]) : '0;
				qb = pass_d_q[QW-1].exch ? AW'(qb_c[i]) : '0;
				if (pass_d_q[QW-1].neg[i]) begin
					xa_s3[i] <= a0 - qa;
					xb_s3[i] <= b0 + qb;
				end else begin
					xa_s3[i] <= a0 + qa;
					xb_s3[i] <= b0 - qb;
				end
			end
			contact_s3 <= pass_d_q[QW-1].contact;
		end
	end

	// stage 4: damping, unity scale when there is no contact
	assign keep_c = contact_s3 ? (KW-1)'((KW-1)'(1) << FB) - (KW-1)'(damping)
		: (KW-1)'((KW-1)'(1) << FB);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				wa_s4[i] <= XW'(xa_s3[i]) * XW'(signed'({1'b0, keep_c}));
				wb_s4[i] <= XW'(xb_s3[i]) * XW'(signed'({1'b0, keep_c}));
			end
			contact_s4 <= contact_s3;
		end
	end

	// round to nearest, halves up, then clip
	always_comb begin
		sat_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			ya_c[i] = YW'((wa_s4[i] + XW'(1 << (FB - 1))) >>> FB);
			yb_c[i] = YW'((wb_s4[i] + XW'(1 << (FB - 1))) >>> FB);
			if (ya_c[i] > SMAX) begin
				oa_c[i*W +: W] = SMAX[W-1:0];
				sat_c = 1'b1;
			end else if (ya_c[i] < SMIN) begin
				oa_c[i*W +: W] = SMIN[W-1:0];
				sat_c = 1'b1;
			end else begin
				oa_c[i*W +: W] = ya_c[i][W-1:0];
			end
			if (yb_c[i] > SMAX) begin
				ob_c[i*W +: W] = SMAX[W-1:0];
				sat_c = 1'b1;
			end else if (yb_c[i] < SMIN) begin
				ob_c[i*W +: W] = SMIN[W-1:0];
				sat_c = 1'b1;
			end else begin
				ob_c[i*W +: W] = yb_c[i][W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (en)
			out_valid <= valid_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			new_vel_a <= oa_c;
			new_vel_b <= ob_c;
			contact   <= contact_s4;
			saturated <= sat_c;
		end
	end

endmodule
`default_nettype wire

[src/sphere_pair_collision_response_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Elastic collision response for sphere pairs, one pair accepted per clock when the
// output side keeps up. A front pipeline of 3 stages forms the offset and relative
// velocity, the squared distance and the dot product, and decides contact; a 4-entry
// queue decouples it from the back pipeline of COMPONENT_WIDTH + 8 stages, whose
// length is set by the bit-per-stage dividers for the exchange term (COMPONENT_WIDTH
// + 3 stages), followed by the exchange, the damping multiply and the
// output register. damping is unsigned Q0.16 and should only be written while no
// pair is in flight.
module sphere_pair_collision_response_unit #(
	parameter int COMPONENT_WIDTH = spcr_pkg::COMPONENT_WIDTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [spcr_pkg::DAMP_W-1:0]      cfg_data,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// pos_a, vel_a, pos_b, vel_b, radius_a, radius_b, mass_a, mass_b
	input  wire logic [spcr_pkg::byte_pad(spcr_pkg::in_width(COMPONENT_WIDTH))-1:0] s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// new_vel_a, new_vel_b
	output logic [spcr_pkg::byte_pad(6*COMPONENT_WIDTH)-1:0] m_tdata,
	// contact, saturated
	output logic [spcr_pkg::USER_W-1:0]           m_tuser
);
	localparam int W  = COMPONENT_WIDTH;
	localparam int IN = spcr_pkg::in_width(W);
	localparam int IW = spcr_pkg::item_width(W);
	localparam int OP = spcr_pkg::byte_pad(6 * W);

	logic [spcr_pkg::DAMP_W-1:0] damping_q;
	logic                        q_full, q_empty, push, pop;
	logic [IW-1:0]               wr_item, rd_item;
	logic [3*W-1:0]              nva, nvb;
	logic                        contact, saturated;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			damping_q <= '0;
		else if (cfg_valid)
			damping_q <= cfg_data;
	end

	spcr_front #(.COMPONENT_WIDTH(W)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_data  (s_tdata[IN-1:0]),
		.q_full   (q_full),
		.push     (push),
		.item     (wr_item)
	);

	spcr_queue #(.DATA_W(IW), .DEPTH(spcr_pkg::QUEUE_DEPTH)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wr_item),
		.pop     (pop),
		.rd_data (rd_item),
		.full    (q_full),
		.empty   (q_empty)
	);

	spcr_back #(.COMPONENT_WIDTH(W)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.damping   (damping_q),
		.item      (rd_item),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.new_vel_a (nva),
		.new_vel_b (nvb),
		.contact   (contact),
		.saturated (saturated)
	);

	assign m_tdata = OP'({nvb, nva});
	always_comb begin
		m_tuser = '0;
		m_tuser[spcr_pkg::USER_CONTACT] = contact;
		m_tuser[spcr_pkg::USER_SAT]     = saturated;
	end

endmodule
`default_nettype wire

[src/spcr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module spcr_checker #(
	parameter int DATA_W = 96,
	parameter int USER_W = spcr_pkg::USER_W
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              cfg_ready,
	input wire logic              m_tvalid,
	input wire logic              m_tready,
	input wire logic [DATA_W-1:0] m_tdata,
	input wire logic [USER_W-1:0] m_tuser
);
	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// pass-through results are never clipped
	a_nocontact_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[spcr_pkg::USER_CONTACT] |-> !m_tuser[spcr_pkg::USER_SAT])
		else $error("saturation flagged without contact");

	// nothing leaves the pipeline in the cycle after reset
	a_reset_empty: assert property (@(posedge clk)
		!$past(arst_n) |-> !m_tvalid)
		else $error("result valid straight after reset");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port not ready");

endmodule

bind sphere_pair_collision_response_unit spcr_checker #(
	.DATA_W (spcr_pkg::byte_pad(6*COMPONENT_WIDTH))
) u_spcr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_ready (cfg_ready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tuser   (m_tuser)
);
`default_nettype wire
